// ----- src/scm_pkg.sv -----
// ----------------------------------------------------------------------------
// scm_pkg: shared types and constants of the serial command master
// Phase codes, sequencer state, item and result records.
// ----------------------------------------------------------------------------
package scm_pkg;

  localparam int unsigned HalfW = 16;

  localparam logic [HalfW-1:0] HalfReset   = 16'd10;
  localparam logic [7:0]       ShortMask   = 8'hC0;
  localparam logic [7:0]       NibbleMask  = 8'hF0;
  localparam logic [3:0]       ShortBits   = 4'd3;
  localparam logic [3:0]       LongBits    = 4'd8;
  localparam logic [3:0]       ReadBits    = 4'd8;
  localparam logic             ActStart    = 1'b1;

  // sequencer phases, one-hot
  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_S1        = 8'b0000_0010,
    PH_S2        = 8'b0000_0100,
    PH_S3        = 8'b0000_1000,
    PH_BIT_LOW   = 8'b0001_0000,
    PH_BIT_HIGH  = 8'b0010_0000,
    PH_READ_HIGH = 8'b0100_0000,
    PH_READ_LOW  = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    phase_e           phase;
    logic [3:0]       bit_cnt;
    logic [HalfW-1:0] wait_cnt;
    logic [7:0]       shreg;
    logic             short_cmd;
    logic             want_rb;
    logic             pin_clk;
    logic             pin_dat;
    logic             pin_drv;
  } state_t;

  typedef struct packed {
    logic       action;
    logic [7:0] command_byte;
    logic       data_pin_in;
  } item_t;

  typedef struct packed {
    logic       clock_pin;
    logic       data_pin_out;
    logic       data_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
  } res_t;

endpackage

// ----- src/scm_if.sv -----
// ----------------------------------------------------------------------------
// scm_if: channel interfaces of the serial command master
// Request, result and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface scm_req_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] command_byte;
  logic       data_pin_in;

  modport source (output valid, action, command_byte, data_pin_in, input ready);
  modport sink   (input valid, action, command_byte, data_pin_in, output ready);
endinterface

interface scm_res_if;
  logic       valid;
  logic       ready;
  logic       clock_pin;
  logic       data_pin_out;
  logic       data_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;

  modport source (output valid, clock_pin, data_pin_out, data_drive, busy_res,
                  done_res, read_byte, input ready);
  modport sink   (input valid, clock_pin, data_pin_out, data_drive, busy_res,
                  done_res, read_byte, output ready);
endinterface

interface scm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- src/serial_command_master_top.sv -----
// ----------------------------------------------------------------------------
// serial_command_master_top: two-wire command master, tick driven
// Input register, sequencer step logic and output register.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  : one transfer per tick. action = 1 starts a command with
//            command_byte (ignored while busy); data_pin_in is the sampled
//            data line level.
//   res_o  : one transfer per request: pin levels, busy, done and the byte
//            read back on the finishing tick.
//   cfg_i  : writes half_period_ticks; always ready, write only while idle.
// Path: a request passes the input register, then its step result is captured
//   in the result register, from which it is offered on res_o.
// Throughput: one request per cycle unless res_o stalls; the sequencer step between
//   the two registers is a single pass of narrow logic with one 16-bit decrement.
// Reset: sequencer idle, clock high, data low and driven, half period 10.
// When res_o stalls, the result register holds; the input register takes
//   one more request, then req_i.ready drops until the result moves on.
// ----------------------------------------------------------------------------
module serial_command_master_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  scm_req_if.sink     req_i,
  scm_res_if.source   res_o,
  scm_cfg_if.sink     cfg_i
);
  import scm_pkg::*;

  localparam state_t StateReset = '{
    phase:     PH_IDLE,
    bit_cnt:   4'd0,
    wait_cnt:  '0,
    shreg:     8'h00,
    short_cmd: 1'b0,
    want_rb:   1'b0,
    pin_clk:   1'b1,
    pin_dat:   1'b0,
    pin_drv:   1'b1
  };

  logic             in_vld_q;
  item_t            in_item_q;
  logic             out_vld_q;
  res_t             out_res_q;
  state_t           state_q;
  state_t           state_d;
  res_t             res_d;
  logic [HalfW-1:0] half_q;
  logic             advance;
  logic             req_ready;

  assign advance   = in_vld_q && (!out_vld_q || res_o.ready);
  assign req_ready = !in_vld_q || advance;
  assign req_i.ready = req_ready;
  assign cfg_i.ready = 1'b1;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HalfReset;
    end else if (cfg_i.valid) begin
      half_q <= cfg_i.data;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ready && req_i.valid) begin
      in_item_q.action       <= req_i.action;
      in_item_q.command_byte <= req_i.command_byte;
      in_item_q.data_pin_in  <= req_i.data_pin_in;
    end
  end

  // sequencer step
  scm_step u_step (
    .cur_i  (state_q),
    .item_i (in_item_q),
    .half_i (half_q),
    .nxt_o  (state_d),
    .res_o  (res_d)
  );

  // sequencer state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StateReset;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      state_q   <= state_d;
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.clock_pin    = out_res_q.clock_pin;
  assign res_o.data_pin_out = out_res_q.data_pin_out;
  assign res_o.data_drive   = out_res_q.data_drive;
  assign res_o.busy_res     = out_res_q.busy_res;
  assign res_o.done_res     = out_res_q.done_res;
  assign res_o.read_byte    = out_res_q.read_byte;

endmodule

// ----- src/scm_step.sv -----
// ----------------------------------------------------------------------------
// scm_step: next-state logic of the waveform sequencer
// Works out the new sequencer state and the result for one tick.
// ----------------------------------------------------------------------------
module scm_step (
  input  scm_pkg::state_t         cur_i,
  input  scm_pkg::item_t          item_i,
  input  logic [scm_pkg::HalfW-1:0] half_i,
  output scm_pkg::state_t         nxt_o,
  output scm_pkg::res_t           res_o
);
  import scm_pkg::*;

  logic [HalfW-1:0] reload;
  logic [HalfW-1:0] wait_dec;
  logic [3:0]       bit_dec;
  logic [7:0]       sh_next;
  logic             done;
  logic [7:0]       rd_byte;
  state_t           nxt;

  // a zero half period counts as one tick
  assign reload   = (half_i == '0) ? HalfW'(1) : half_i;
  assign wait_dec = cur_i.wait_cnt - HalfW'(1);
  assign bit_dec  = cur_i.bit_cnt - 4'd1;
  assign sh_next  = {cur_i.shreg[6:0], 1'b0};

  // one tick of the sequencer
  always_comb begin
    nxt     = cur_i;
    done    = 1'b0;
    rd_byte = '0;
    if (cur_i.phase == PH_IDLE) begin
      if (item_i.action == ActStart) begin
        nxt.short_cmd = (item_i.command_byte & ShortMask) == ShortMask;
        nxt.want_rb   = (item_i.command_byte & NibbleMask) == 8'h00;
        nxt.bit_cnt   = ((item_i.command_byte & ShortMask) == ShortMask) ?
                        ShortBits : LongBits;
        nxt.shreg     = item_i.command_byte;
        nxt.pin_drv   = 1'b1;
        nxt.pin_dat   = 1'b0;
        nxt.pin_clk   = 1'b0;
        nxt.wait_cnt  = reload;
        nxt.phase     = PH_S1;
      end
    end else begin
      nxt.wait_cnt = wait_dec;
      if (wait_dec == '0) begin
        case (cur_i.phase)
          PH_S1: begin
            nxt.pin_clk  = 1'b1;
            nxt.wait_cnt = reload;
            nxt.phase    = PH_S2;
          end
          PH_S2: begin
            nxt.pin_dat  = 1'b1;
            nxt.wait_cnt = reload;
            nxt.phase    = PH_S3;
          end
          PH_S3: begin
            nxt.pin_clk  = 1'b0;
            nxt.pin_dat  = cur_i.shreg[7];
            nxt.wait_cnt = reload;
            nxt.phase    = PH_BIT_LOW;
          end
          PH_BIT_LOW: begin
            nxt.pin_clk  = 1'b1;
            nxt.wait_cnt = reload;
            nxt.phase    = PH_BIT_HIGH;
          end
          PH_BIT_HIGH: begin
            nxt.pin_clk = 1'b0;
            nxt.shreg   = sh_next;
            nxt.bit_cnt = bit_dec;
            if (bit_dec != 4'd0) begin
              nxt.pin_dat  = sh_next[7];
              nxt.wait_cnt = reload;
              nxt.phase    = PH_BIT_LOW;
            end else begin
              nxt.pin_dat = 1'b0;
              if (!cur_i.short_cmd && cur_i.want_rb) begin
                // release data and start the read-back
                nxt.pin_drv  = 1'b0;
                nxt.pin_clk  = 1'b1;
                nxt.bit_cnt  = ReadBits;
                nxt.wait_cnt = reload;
                nxt.phase    = PH_READ_HIGH;
              end else begin
                done = 1'b1;
              end
            end
          end
          PH_READ_HIGH: begin
            nxt.shreg    = {cur_i.shreg[6:0], item_i.data_pin_in};
            nxt.pin_clk  = 1'b0;
            nxt.wait_cnt = reload;
            nxt.phase    = PH_READ_LOW;
          end
          PH_READ_LOW: begin
            nxt.bit_cnt = bit_dec;
            if (bit_dec != 4'd0) begin
              nxt.pin_clk  = 1'b1;
              nxt.wait_cnt = reload;
              nxt.phase    = PH_READ_HIGH;
            end else begin
              nxt.pin_drv = 1'b1;
              nxt.pin_dat = 1'b0;
              rd_byte     = cur_i.shreg;
              done        = 1'b1;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
        if (done) begin
          nxt.phase    = PH_IDLE;
          nxt.wait_cnt = '0;
        end
      end
    end
  end

  assign nxt_o = nxt;

  // result of this tick
  always_comb begin
    res_o.clock_pin    = nxt.pin_clk;
    res_o.data_pin_out = nxt.pin_dat;
    res_o.data_drive   = nxt.pin_drv;
    res_o.busy_res     = nxt.phase != PH_IDLE;
    res_o.done_res     = done;
    res_o.read_byte    = rd_byte;
  end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the serial command master
// Drives tick items through the request channel, predicts the pin levels,
// busy, done and read-back byte of every tick, and checks each result
// transfer in order against the prediction. The half period is changed
// between runs of traffic, from zero up to its largest value.
// ----------------------------------------------------------------------------

// Tracks the sequencer and holds the pin levels expected for each tick.
class wave_scoreboard;
  scm_pkg::res_t   pending_pins[$];
  scm_pkg::phase_e phase;
  logic [3:0]      bit_cnt;
  logic [15:0]     wait_cnt;
  logic [15:0]     half_ticks;
  logic [7:0]      shreg;
  logic            short_cmd;
  logic            want_rb;
  logic            pin_clk;
  logic            pin_dat;
  logic            pin_drv;
  int              faults;
  int              checked;
  int              ticks;
  int              finished;
  int              readbacks;

  function new();
    phase      = scm_pkg::PH_IDLE;
    bit_cnt    = '0;
    wait_cnt   = '0;
    half_ticks = scm_pkg::HalfReset;
    shreg      = '0;
    short_cmd  = 1'b0;
    want_rb    = 1'b0;
    pin_clk    = 1'b1;
    pin_dat    = 1'b0;
    pin_drv    = 1'b1;
    faults     = 0;
    checked    = 0;
    ticks      = 0;
    finished   = 0;
    readbacks  = 0;
  endfunction

  function void set_half(logic [15:0] v);
    half_ticks = v;
  endfunction

  // a zero half period still waits one tick
  function logic [15:0] step_load();
    return (half_ticks == 16'd0) ? 16'd1 : half_ticks;
  endfunction

  function bit busy();
    return phase != scm_pkg::PH_IDLE;
  endfunction

  function int pending();
    return pending_pins.size();
  endfunction

  // advance the sequencer by one accepted tick and queue its pin levels
  function void note_tick(scm_pkg::item_t it);
    scm_pkg::res_t want;
    logic          fin;
    logic [7:0]    rb;
    fin = 1'b0;
    rb  = 8'h00;
    ticks++;
    if (phase == scm_pkg::PH_IDLE) begin
      if (it.action == scm_pkg::ActStart) begin
        short_cmd = (it.command_byte & scm_pkg::ShortMask) == scm_pkg::ShortMask;
        want_rb   = (it.command_byte & scm_pkg::NibbleMask) == 8'h00;
        bit_cnt   = short_cmd ? scm_pkg::ShortBits : scm_pkg::LongBits;
        shreg     = it.command_byte;
        pin_drv   = 1'b1;
        pin_dat   = 1'b0;
        pin_clk   = 1'b0;
        wait_cnt  = step_load();
        phase     = scm_pkg::PH_S1;
      end
    end else begin
      wait_cnt = wait_cnt - 16'd1;
      if (wait_cnt == 16'd0) begin
        case (phase)
          // start condition
          scm_pkg::PH_S1: begin
            pin_clk  = 1'b1;
            wait_cnt = step_load();
            phase    = scm_pkg::PH_S2;
          end
          scm_pkg::PH_S2: begin
            pin_dat  = 1'b1;
            wait_cnt = step_load();
            phase    = scm_pkg::PH_S3;
          end
          scm_pkg::PH_S3: begin
            pin_clk  = 1'b0;
            pin_dat  = shreg[7];
            wait_cnt = step_load();
            phase    = scm_pkg::PH_BIT_LOW;
          end
          // command shift, MSB first
          scm_pkg::PH_BIT_LOW: begin
            pin_clk  = 1'b1;
            wait_cnt = step_load();
            phase    = scm_pkg::PH_BIT_HIGH;
          end
          scm_pkg::PH_BIT_HIGH: begin
            pin_clk = 1'b0;
            shreg   = shreg << 1;
            bit_cnt = bit_cnt - 4'd1;
            if (bit_cnt != 4'd0) begin
              pin_dat  = shreg[7];
              wait_cnt = step_load();
              phase    = scm_pkg::PH_BIT_LOW;
            end else begin
              pin_dat = 1'b0;
              if (!short_cmd && want_rb) begin
                pin_drv  = 1'b0;
                pin_clk  = 1'b1;
                bit_cnt  = scm_pkg::ReadBits;
                wait_cnt = step_load();
                phase    = scm_pkg::PH_READ_HIGH;
              end else begin
                fin = 1'b1;
              end
            end
          end
          // read-back, sampled at the end of the high half
          scm_pkg::PH_READ_HIGH: begin
            shreg    = {shreg[6:0], it.data_pin_in};
            pin_clk  = 1'b0;
            wait_cnt = step_load();
            phase    = scm_pkg::PH_READ_LOW;
          end
          scm_pkg::PH_READ_LOW: begin
            bit_cnt = bit_cnt - 4'd1;
            if (bit_cnt != 4'd0) begin
              pin_clk  = 1'b1;
              wait_cnt = step_load();
              phase    = scm_pkg::PH_READ_HIGH;
            end else begin
              pin_drv = 1'b1;
              pin_dat = 1'b0;
              rb      = shreg;
              fin     = 1'b1;
              readbacks++;
            end
          end
          default: fin = 1'b1;
        endcase
        if (fin) begin
          phase    = scm_pkg::PH_IDLE;
          wait_cnt = '0;
          finished++;
        end
      end
    end
    want.clock_pin    = pin_clk;
    want.data_pin_out = pin_dat;
    want.data_drive   = pin_drv;
    want.busy_res     = (phase != scm_pkg::PH_IDLE);
    want.done_res     = fin;
    want.read_byte    = rb;
    pending_pins.push_back(want);
  endfunction

  function void log_fault(string what, scm_pkg::res_t want, scm_pkg::res_t got);
    faults++;
    if (faults <= 10)
      $display("%s: exp clk=%0b dat=%0b drv=%0b busy=%0b done=%0b byte=%02h | got clk=%0b dat=%0b drv=%0b busy=%0b done=%0b byte=%02h",
               what, want.clock_pin, want.data_pin_out, want.data_drive, want.busy_res,
               want.done_res, want.read_byte, got.clock_pin, got.data_pin_out,
               got.data_drive, got.busy_res, got.done_res, got.read_byte);
  endfunction

  // compare one result transfer with the oldest expectation
  function void check_pins(scm_pkg::res_t got);
    scm_pkg::res_t want;
    string         diff;
    if (pending_pins.size() == 0) begin
      log_fault("result with nothing pending", '0, got);
      return;
    end
    want = pending_pins.pop_front();
    checked++;
    diff = "";
    if (got.clock_pin    !== want.clock_pin)    diff = {diff, " clock_pin"};
    if (got.data_pin_out !== want.data_pin_out) diff = {diff, " data_pin_out"};
    if (got.data_drive   !== want.data_drive)   diff = {diff, " data_drive"};
    if (got.busy_res     !== want.busy_res)     diff = {diff, " busy_res"};
    if (got.done_res     !== want.done_res)     diff = {diff, " done_res"};
    if (got.read_byte    !== want.read_byte)    diff = {diff, " read_byte"};
    if (diff != "") log_fault({"tick", diff}, want, got);
  endfunction

  function void flush_leftover();
    while (pending_pins.size() != 0)
      log_fault("result never arrived", pending_pins.pop_front(), '0);
  endfunction
endclass

module testbench;
  import scm_pkg::*;

  localparam logic ActTick    = ~ActStart;
  localparam int   PhaseItems = 210;
  localparam int   PhaseCount = 6;

  // receiver stall patterns
  typedef enum int {
    RX_FREE,
    RX_COIN,
    RX_PERIODIC,
    RX_CHOKE
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;

  scm_req_if req_if ();
  scm_res_if res_if ();
  scm_cfg_if cfg_if ();

  serial_command_master_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  wave_scoreboard sb;
  int             burst_left;
  bit             req_live;
  int             sent_items;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // both channels sampled at the rising edge, results checked first
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready)
        sb.check_pins({res_if.clock_pin, res_if.data_pin_out, res_if.data_drive,
                       res_if.busy_res, res_if.done_res, res_if.read_byte});
      if (req_if.valid && req_if.ready)
        sb.note_tick({req_if.action, req_if.command_byte, req_if.data_pin_in});
    end
  end

  // receiver back-pressure, one pattern per stretch
  initial begin : rx_stall
    rx_mode_e mode;
    int       span;
    int       k;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 96);
      for (k = 0; k < span; k++) begin
        @(negedge clk_i);
        case (mode)
          RX_FREE:     res_if.ready <= 1'b1;
          RX_COIN:     res_if.ready <= ($urandom_range(0, 1) == 1);
          RX_PERIODIC: res_if.ready <= (k % 4) != 3;
          default:     res_if.ready <= (k % 9) < 3;
        endcase
      end
    end
  end

  // all driving tasks start and end at a falling edge
  task automatic drop_valid();
    if (req_live) begin
      req_if.valid <= 1'b0;
      req_live = 1'b0;
    end
  endtask

  // one tick transfer, with a random gap at the start of each burst
  task automatic push_tick(input logic act, input logic [7:0] cmd, input logic din);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        drop_valid();
        repeat (gap) @(negedge clk_i);
      end
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= act;
    req_if.command_byte <= cmd;
    req_if.data_pin_in  <= din;
    req_live = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    burst_left--;
    sent_items++;
    @(negedge clk_i);
  endtask

  // hold the sender until every expected result has come back
  task automatic wait_drained();
    drop_valid();
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_half(input logic [15:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    sb.set_half(v);
  endtask

  // start a command and tick until it has finished; busy starts mixed in
  task automatic run_transaction(input logic [7:0] cmd, input int pause_at);
    int n;
    n = 0;
    push_tick(ActStart, cmd, 1'($urandom));
    while (sb.busy()) begin
      if (n == pause_at) wait_drained();
      push_tick(($urandom_range(0, 9) == 0) ? ActStart : ActTick, 8'($urandom),
                1'($urandom));
      n++;
    end
  endtask

  initial begin : stimulus
    logic [15:0] plan [PhaseCount];
    logic [7:0]  cmd;
    int          p;
    int          mark;
    int          done_items;
    bit          first;
    plan = '{16'd1, 16'd2, 16'd3, 16'd1, 16'd4, 16'd2};
    sb = new();
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.action       = ActTick;
    req_if.command_byte = 8'h00;
    req_if.data_pin_in  = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.data         = '0;
    req_live   = 1'b0;
    burst_left = 0;
    sent_items = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: zero half period, short command with a start while busy,
    // then an eight-bit command without read-back
    write_half(16'd0);
    push_tick(ActStart, 8'hFF, 1'b0);
    push_tick(ActStart, 8'h00, 1'b1);
    while (sb.busy()) push_tick(ActTick, 8'($urandom), 1'($urandom));
    push_tick(ActTick, 8'h5A, 1'b1);
    run_transaction(8'h80, -1);

    // random traffic over several half periods
    for (p = 0; p < PhaseCount; p++) begin
      wait_drained();
      write_half(plan[p]);
      done_items = 0;
      first = 1'b1;
      while (done_items < PhaseItems) begin
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 4)) push_tick(ActTick, 8'($urandom), 1'($urandom));
        end else begin
          cmd = 8'($urandom);
          case ($urandom_range(0, 2))
            0:       cmd[7:6] = 2'b11;
            1:       cmd[7:4] = 4'h0;
            default: ;
          endcase
          mark = sent_items;
          run_transaction(cmd, first ? $urandom_range(1, 8) : -1);
          done_items += sent_items - mark;
          first = 1'b0;
        end
      end
    end

    // largest half period: a read-back command that stays in its first delay
    wait_drained();
    write_half(16'hFFFF);
    cmd = 8'($urandom);
    cmd[7:4] = 4'h0;
    push_tick(ActStart, cmd, 1'($urandom));
    repeat (300) push_tick(1'($urandom), 8'($urandom), 1'($urandom));

    wait_drained();
    repeat (8) @(negedge clk_i);
    sb.flush_leftover();
    $display("Run covered %0d ticks and %0d finished commands, %0d with read-back,",
             sb.ticks, sb.finished, sb.readbacks);
    $display("half periods from zero to 65535; %0d results compared, %0d faults.",
             sb.checked, sb.faults);
    if (sb.faults == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
